### hw/rtl/thb_pkg.sv
// Shared constants and types for the bytewise Toeplitz hash core.
// Used by thb_key_regs, thb_window and toeplitz_hash_bytewise_core.
`default_nettype none

package thb_pkg;

   // Key storage: six 64-bit words and one 32-bit word, byte 0 in the top bits
   localparam int KEY_STORE_BYTES   = 52;
   localparam int KEY_STORE_BITS    = KEY_STORE_BYTES * 8;
   localparam int KEY_WORD_W        = 64;
   localparam int KEY_FULL_WORDS    = 6;
   localparam int KEY_TAIL_W        = 32;
   localparam int KEY_BYTES_DEFAULT = 52;

   // Hash and payload widths
   localparam int HASH_W = 32;
   localparam int BYTE_W = 8;
   localparam int SPAN_W = HASH_W + BYTE_W;

   // CSR port
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_KEY_0_7   = 3'd0;
   localparam csr_index_type CSR_KEY_8_15  = 3'd1;
   localparam csr_index_type CSR_KEY_16_23 = 3'd2;
   localparam csr_index_type CSR_KEY_24_31 = 3'd3;
   localparam csr_index_type CSR_KEY_32_39 = 3'd4;
   localparam csr_index_type CSR_KEY_40_47 = 3'd5;
   localparam csr_index_type CSR_KEY_48_51 = 3'd6;

   typedef logic [KEY_STORE_BITS-1:0] key_flat_type;
   typedef logic [HASH_W-1:0]         hash_type;

endpackage

`default_nettype wire

### hw/rtl/thb_key_regs.sv
// Hash key register file: seven CSR words, flattened byte 0 first (MSB).
// Depends on thb_pkg.
`default_nettype none

module thb_key_regs (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_en,
   input  wire thb_pkg::csr_index_type             csr_index,
   input  wire logic [thb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output thb_pkg::key_flat_type                   key_flat
);

   logic [thb_pkg::KEY_WORD_W-1:0] key_word_ff [thb_pkg::KEY_FULL_WORDS];
   logic [thb_pkg::KEY_WORD_W-1:0] key_word_in [thb_pkg::KEY_FULL_WORDS];
   logic [thb_pkg::KEY_TAIL_W-1:0] key_tail_ff;
   logic [thb_pkg::KEY_TAIL_W-1:0] key_tail_in;

   // Register write decode; unknown indexes are dropped
   always_comb begin
      for (int w = 0; w < thb_pkg::KEY_FULL_WORDS; w++) begin
         key_word_in[w] = key_word_ff[w];
      end
      key_tail_in = key_tail_ff;
      if (csr_write_en) begin
         case (csr_index)
            thb_pkg::CSR_KEY_0_7:   key_word_in[0] = csr_wdata;
            thb_pkg::CSR_KEY_8_15:  key_word_in[1] = csr_wdata;
            thb_pkg::CSR_KEY_16_23: key_word_in[2] = csr_wdata;
            thb_pkg::CSR_KEY_24_31: key_word_in[3] = csr_wdata;
            thb_pkg::CSR_KEY_32_39: key_word_in[4] = csr_wdata;
            thb_pkg::CSR_KEY_40_47: key_word_in[5] = csr_wdata;
            thb_pkg::CSR_KEY_48_51: key_tail_in = csr_wdata[thb_pkg::KEY_TAIL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < thb_pkg::KEY_FULL_WORDS; w++) begin
            key_word_ff[w] <= '0;
         end
         key_tail_ff <= '0;
      end else begin
         for (int w = 0; w < thb_pkg::KEY_FULL_WORDS; w++) begin
            key_word_ff[w] <= key_word_in[w];
         end
         key_tail_ff <= key_tail_in;
      end
   end

   // Big-endian flattening: word 0 on top, tail word at the bottom
   assign key_flat = {key_word_ff[0], key_word_ff[1], key_word_ff[2], key_word_ff[3],
                      key_word_ff[4], key_word_ff[5], key_tail_ff};

endmodule

`default_nettype wire

### hw/rtl/thb_window.sv
// One-byte Toeplitz step: picks the five key bytes at the offset (wrapping)
// and folds the eight bit windows into the accumulator. Depends on thb_pkg.
`default_nettype none

module thb_window #(
   parameter int KEY_BYTES = thb_pkg::KEY_BYTES_DEFAULT
) (
   input  wire thb_pkg::key_flat_type               key_flat,
   input  wire logic [$clog2(KEY_BYTES)-1:0]        key_ofs,
   input  wire logic [thb_pkg::BYTE_W-1:0]          data_byte,
   input  wire thb_pkg::hash_type                   accum,
   output thb_pkg::hash_type                        accum_next
);

   localparam int OFS_W   = $clog2(KEY_BYTES);
   localparam int KEY_BITS = KEY_BYTES * 8;
   localparam int EXT_W   = KEY_BITS + thb_pkg::HASH_W;
   localparam int SH_W    = OFS_W + 3;

   logic [KEY_BITS-1:0]           key_used;
   logic [EXT_W-1:0]              key_ext;
   logic [OFS_W-1:0]              ofs_rev;
   logic [SH_W-1:0]               span_lsb;
   logic [thb_pkg::SPAN_W-1:0]    span;

   // Key as the hash sees it; bytes past the stored key read as zero
   for (genvar n = 0; n < KEY_BYTES; n++) begin : g_key_byte
      if (n < thb_pkg::KEY_STORE_BYTES) begin : g_stored
         assign key_used[KEY_BITS-1-8*n -: 8] =
            key_flat[thb_pkg::KEY_STORE_BITS-1-8*n -: 8];
      end else begin : g_zero
         assign key_used[KEY_BITS-1-8*n -: 8] = 8'h00;
      end
   end

   // Repeat the first four key bytes below the end to cover the wrap
   assign key_ext  = {key_used, key_used[KEY_BITS-1 -: thb_pkg::HASH_W]};
   assign ofs_rev  = OFS_W'(KEY_BYTES - 1) - key_ofs;
   assign span_lsb = {ofs_rev, 3'b000};
   assign span     = key_ext[span_lsb +: thb_pkg::SPAN_W];

   // Bit 7 of the byte uses the window at the span top, bit 0 the lowest one
   always_comb begin
      accum_next = accum;
      for (int b = 0; b < thb_pkg::BYTE_W; b++) begin
         if (data_byte[7-b]) begin
            accum_next = accum_next ^ span[thb_pkg::SPAN_W-1-b -: thb_pkg::HASH_W];
         end
      end
   end

endmodule

`default_nettype wire

### hw/rtl/toeplitz_hash_bytewise_core.sv
// Top level of the bytewise 32-bit Toeplitz (RSS) hash core.
// Depends on thb_pkg, thb_key_regs and thb_window.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   req     | in        | req_valid / req_ready  | req_data_byte, req_last_byte
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_hash_value
//   csr     | in        | csr_write_en           | csr_index, csr_wdata
//
// One byte per cycle unless a last byte waits for the result register. A byte
// enters the input register; the key window select and the eight-way XOR fold
// run between that register and the accumulator, and the last byte's hash
// lands in the result register, which drives rsp_valid and rsp_hash_value.
// Reset clears the key, the accumulator and the key offset.
// A held result stalls only a last byte; other bytes keep flowing.
`default_nettype none

module toeplitz_hash_bytewise_core #(
   parameter int KEY_BYTES = thb_pkg::KEY_BYTES_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // byte stream
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [thb_pkg::BYTE_W-1:0]      req_data_byte,
   input  wire logic                            req_last_byte,
   // hash results
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [thb_pkg::HASH_W-1:0]      rsp_hash_value,
   // key registers
   input  wire logic                            csr_write_en,
   input  wire thb_pkg::csr_index_type          csr_index,
   input  wire logic [thb_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int OFS_W = $clog2(KEY_BYTES);

   thb_pkg::key_flat_type          key_flat;
   thb_pkg::hash_type              accum_next;

   logic                           s1_valid_ff, s1_valid_in;
   logic [thb_pkg::BYTE_W-1:0]     s1_data_ff, s1_data_in;
   logic                           s1_last_ff, s1_last_in;
   thb_pkg::hash_type              accum_ff, accum_in;
   logic [OFS_W-1:0]               ofs_ff, ofs_in;
   logic [OFS_W-1:0]               ofs_step;
   logic                           rsp_valid_ff, rsp_valid_in;
   thb_pkg::hash_type              rsp_hash_ff, rsp_hash_in;

   logic                           out_free;
   logic                           s1_fire;
   logic                           req_xfer;

   thb_key_regs u_key_regs (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .key_flat     (key_flat)
   );

   thb_window #(
      .KEY_BYTES (KEY_BYTES)
   ) u_window (
      .key_flat   (key_flat),
      .key_ofs    (ofs_ff),
      .data_byte  (s1_data_ff),
      .accum      (accum_ff),
      .accum_next (accum_next)
   );

   // Flow control: a last byte waits only for room in the result register
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_xfer  = req_valid && req_ready;

   // Key offset advance with wrap at the key length
   assign ofs_step = (ofs_ff == OFS_W'(KEY_BYTES - 1)) ? '0 : ofs_ff + OFS_W'(1);

   // Input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      s1_last_in  = s1_last_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data_byte;
         s1_last_in  = req_last_byte;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // Hash state and result register
   always_comb begin
      accum_in     = accum_ff;
      ofs_in       = ofs_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (s1_fire) begin
         if (s1_last_ff) begin
            accum_in     = '0;
            ofs_in       = '0;
            rsp_hash_in  = accum_next;
            rsp_valid_in = 1'b1;
         end else begin
            accum_in = accum_next;
            ofs_in   = ofs_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         accum_ff     <= '0;
         ofs_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         accum_ff     <= accum_in;
         ofs_ff       <= ofs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      s1_last_ff  <= s1_last_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

`default_nettype wire
